@@ src/lasf_pkg.sv @@
// ----------------------------------------------------------------------------
// lasf_pkg
// shared constants and types for the local alignment score fill block
// ----------------------------------------------------------------------------
`default_nettype none

package lasf_pkg;

  localparam int DEF_MAX_A_LEN  = 1024;
  localparam int DEF_SCORE_BITS = 20;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 11;
  localparam int ROW_BITS      = 13;
  localparam int COL_BITS      = 11;
  localparam int SYM_BITS      = 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_MATCH_AWARD    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MISMATCH_AWARD = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAP_OPEN       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAP_EXTEND     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAPS_DIS       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MISMATCHES_DIS = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_A_LENGTH       = 3'd6;

  localparam logic [ROW_BITS-1:0] ROW_TOP = 13'd8191;

  typedef struct packed {
    logic [7:0] match_award;
    logic [7:0] mismatch_award;
    logic [7:0] open_cost;
    logic [7:0] extend_cost;
    logic       gaps_dis;
    logic       mm_dis;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    match_award:    8'h01,
    mismatch_award: 8'hFF,
    open_cost:      8'hFE,
    extend_cost:    8'hFF,
    gaps_dis:       1'b0,
    mm_dis:         1'b0
  };

  localparam logic [COL_BITS-1:0] A_LENGTH_RESET = 11'd1024;

endpackage

`default_nettype wire

@@ src/local_alignment_score_fill_top.sv @@
// ----------------------------------------------------------------------------
// local_alignment_score_fill_top
// affine-gap local alignment row fill with per-row best match score
//
// input channel: cmd 0 writes symbol into the sequence a store at position
//   (positions at or above MAX_A_LEN are dropped)
// cmd 1 runs one sequence b symbol across columns 1..a_length (column 1 only
//   when a_length is 0, capped at MAX_A_LEN), reading the previous row from
//   the row memory and writing the new row back, one column per cycle
//   through the single row memory port pair; the next transaction is taken
//   only once the row's result has moved into the output register
// output channel: row number, best match score and leftmost best column,
//   held in an output register; a new row may start while it waits, and a
//   finished row waits in place until the output register is free
// config port: always ready, write only while idle
// reset: control and configuration registers to defaults, memories are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module local_alignment_score_fill_top #(
  parameter int MAX_A_LEN  = lasf_pkg::DEF_MAX_A_LEN,
  parameter int SCORE_BITS = lasf_pkg::DEF_SCORE_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,

  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lasf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [lasf_pkg::CFG_DATA_BITS-1:0]  cfg_data,

  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_cmd,
  input  wire logic [lasf_pkg::SYM_BITS-1:0]       in_symbol,
  input  wire logic [9:0]                          in_position,
  input  wire logic                                in_first_row,

  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [lasf_pkg::ROW_BITS-1:0]            out_row_number,
  output logic [SCORE_BITS-1:0]                    out_best_score,
  output logic [lasf_pkg::COL_BITS-1:0]            out_best_column
);

  localparam int AW = (MAX_A_LEN > 1) ? $clog2(MAX_A_LEN) : 1;
  localparam int RW = 3 * SCORE_BITS;
  localparam logic [AW-1:0] LAST_COL = AW'(MAX_A_LEN - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // configuration
  lasf_pkg::cfg_t                    cfg_r;
  logic [lasf_pkg::COL_BITS-1:0]     a_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= lasf_pkg::CFG_RESET;
      a_len_r <= lasf_pkg::A_LENGTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lasf_pkg::REG_MATCH_AWARD:    cfg_r.match_award    <= cfg_data[7:0];
        lasf_pkg::REG_MISMATCH_AWARD: cfg_r.mismatch_award <= cfg_data[7:0];
        lasf_pkg::REG_GAP_OPEN:       cfg_r.open_cost      <= cfg_data[7:0];
        lasf_pkg::REG_GAP_EXTEND:     cfg_r.extend_cost    <= cfg_data[7:0];
        lasf_pkg::REG_GAPS_DIS:       cfg_r.gaps_dis       <= cfg_data[0];
        lasf_pkg::REG_MISMATCHES_DIS: cfg_r.mm_dis         <= cfg_data[0];
        lasf_pkg::REG_A_LENGTH:       a_len_r              <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  logic [1:0]                      state_r;
  logic                            issuing_r;
  logic [AW-1:0]                   rd_col_r;
  logic [AW-1:0]                   n_last_r;
  logic [AW-1:0]                   n_last_nxt;
  logic                            s1_r;
  logic                            s1_last_r;
  logic [AW-1:0]                   s1_col_r;
  logic                            s2_r;
  logic                            s2_last_r;
  logic [AW-1:0]                   s2_col_r;
  logic [SCORE_BITS-1:0]           s2_m_r;
  logic [lasf_pkg::SYM_BITS-1:0]   sym_b_r;
  logic                            first_r;
  logic [lasf_pkg::ROW_BITS-1:0]   row_cnt_r;
  logic [lasf_pkg::ROW_BITS-1:0]   row_cnt_nxt;
  logic [SCORE_BITS-1:0]           best_r;
  logic [lasf_pkg::COL_BITS-1:0]   best_col_r;
  logic                            out_valid_r;
  logic [lasf_pkg::ROW_BITS-1:0]   out_row_r;
  logic [SCORE_BITS-1:0]           out_score_r;
  logic [lasf_pkg::COL_BITS-1:0]   out_col_r;

  logic                            in_acc;
  logic                            load_acc;
  logic                            proc_acc;
  logic                            pos_ok;
  logic                            rd_en;
  logic                            out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_acc = in_acc && !in_cmd;
  assign proc_acc = in_acc && in_cmd;
  assign pos_ok   = (int'(in_position) < MAX_A_LEN);
  assign rd_en    = (state_r == ST_RUN) && issuing_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (int'(a_len_r) > MAX_A_LEN) begin
      n_last_nxt = LAST_COL;
    end else if (a_len_r == '0) begin
      n_last_nxt = '0;
    end else begin
      n_last_nxt = AW'(a_len_r - 11'd1);
    end
    if (in_first_row) begin
      row_cnt_nxt = 13'd1;
    end else if (row_cnt_r < lasf_pkg::ROW_TOP) begin
      row_cnt_nxt = row_cnt_r + 13'd1;
    end else begin
      row_cnt_nxt = row_cnt_r;
    end
  end

  // memories
  logic [lasf_pkg::SYM_BITS-1:0]   sym_mem [MAX_A_LEN];
  logic [RW-1:0]                   row_mem [MAX_A_LEN];
  logic [lasf_pkg::SYM_BITS-1:0]   sym_q;
  logic [RW-1:0]                   row_q;
  logic [RW-1:0]                   row_wr;

  always_ff @(posedge clk) begin
    if (load_acc && pos_ok) begin
      sym_mem[AW'(in_position)] <= in_symbol;
    end
    if (rd_en) begin
      sym_q <= sym_mem[rd_col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_r) begin
      row_mem[s1_col_r] <= row_wr;
    end
    if (rd_en) begin
      row_q <= row_mem[rd_col_r];
    end
  end

  // cell datapath
  logic [SCORE_BITS-1:0] u_m, u_a, u_b;
  logic [SCORE_BITS-1:0] d_m_r, d_a_r, d_b_r;
  logic [SCORE_BITS-1:0] l_m_r, l_a_r, l_b_r;
  logic [SCORE_BITS-1:0] new_m, new_a, new_b;
  logic                  zero_gap;

  assign zero_gap = first_r || cfg_r.gaps_dis;
  assign u_m      = first_r  ? '0 : row_q[RW-1 -: SCORE_BITS];
  assign u_a      = zero_gap ? '0 : row_q[2*SCORE_BITS-1 -: SCORE_BITS];
  assign u_b      = zero_gap ? '0 : row_q[SCORE_BITS-1:0];
  assign row_wr   = {new_m, new_a, new_b};

  lasf_cell #(
    .SCORE_BITS(SCORE_BITS)
  ) u_cell (
    .sym_a (sym_q),
    .sym_b (sym_b_r),
    .cfg   (cfg_r),
    .d_m   (d_m_r),
    .d_a   (d_a_r),
    .d_b   (d_b_r),
    .u_m   (u_m),
    .u_a   (u_a),
    .u_b   (u_b),
    .l_m   (l_m_r),
    .l_a   (l_a_r),
    .l_b   (l_b_r),
    .new_m (new_m),
    .new_a (new_a),
    .new_b (new_b)
  );

  always_ff @(posedge clk) begin
    if (proc_acc) begin
      d_m_r <= '0;
      d_a_r <= '0;
      d_b_r <= '0;
      l_m_r <= '0;
      l_a_r <= '0;
      l_b_r <= '0;
    end else if (s1_r) begin
      d_m_r <= u_m;
      d_a_r <= u_a;
      d_b_r <= u_b;
      l_m_r <= new_m;
      l_a_r <= new_a;
      l_b_r <= new_b;
    end
    if (proc_acc) begin
      sym_b_r  <= in_symbol;
      first_r  <= in_first_row;
      n_last_r <= n_last_nxt;
    end
    s1_col_r <= rd_col_r;
    s2_col_r <= s1_col_r;
    s2_m_r   <= new_m;
  end

  // sequencing and best tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issuing_r   <= 1'b0;
      rd_col_r    <= '0;
      s1_r        <= 1'b0;
      s1_last_r   <= 1'b0;
      s2_r        <= 1'b0;
      s2_last_r   <= 1'b0;
      row_cnt_r   <= '0;
      best_r      <= '0;
      best_col_r  <= 11'd1;
      out_valid_r <= 1'b0;
    end else begin
      s1_r      <= rd_en;
      s1_last_r <= rd_en && (rd_col_r == n_last_r);
      s2_r      <= s1_r;
      s2_last_r <= s1_r && s1_last_r;

      unique case (state_r)
        ST_IDLE: begin
          if (proc_acc) begin
            state_r    <= ST_RUN;
            issuing_r  <= 1'b1;
            rd_col_r   <= '0;
            row_cnt_r  <= row_cnt_nxt;
            best_r     <= '0;
            best_col_r <= 11'd1;
          end
        end
        ST_RUN: begin
          if (issuing_r) begin
            rd_col_r <= rd_col_r + 1'b1;
            if (rd_col_r == n_last_r) begin
              issuing_r <= 1'b0;
            end
          end
          if (s2_r && (s2_m_r > best_r)) begin
            best_r     <= s2_m_r;
            best_col_r <= lasf_pkg::COL_BITS'({1'b0, s2_col_r} + 1'b1);
          end
          if (s2_last_r) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      out_row_r   <= row_cnt_r;
      out_score_r <= best_r;
      out_col_r   <= best_col_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_number  = out_row_r;
  assign out_best_score  = out_score_r;
  assign out_best_column = out_col_r;

`ifndef NO_ASSERTIONS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!s1_r && !s2_r && !issuing_r))
    else $error("column pipeline busy while idle");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && s1_r) |-> (rd_col_r != s1_col_r))
    else $error("row memory read and write hit the same column");

  a_issue_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && (rd_col_r == n_last_r)) |=> !issuing_r)
    else $error("column issue ran past the last column");

  a_best_col_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_col_r != '0))
    else $error("best column is zero");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result produced outside the finish state");
`endif

endmodule

`default_nettype wire

@@ src/lasf_cell.sv @@
// ----------------------------------------------------------------------------
// lasf_cell
// one cell of the affine-gap recurrence: match, gap in a and gap in b scores
// ----------------------------------------------------------------------------
`default_nettype none

module lasf_cell #(
  parameter int SCORE_BITS = lasf_pkg::DEF_SCORE_BITS
) (
  input  wire logic [lasf_pkg::SYM_BITS-1:0] sym_a,
  input  wire logic [lasf_pkg::SYM_BITS-1:0] sym_b,
  input  wire lasf_pkg::cfg_t                cfg,
  input  wire logic [SCORE_BITS-1:0]         d_m,
  input  wire logic [SCORE_BITS-1:0]         d_a,
  input  wire logic [SCORE_BITS-1:0]         d_b,
  input  wire logic [SCORE_BITS-1:0]         u_m,
  input  wire logic [SCORE_BITS-1:0]         u_a,
  input  wire logic [SCORE_BITS-1:0]         u_b,
  input  wire logic [SCORE_BITS-1:0]         l_m,
  input  wire logic [SCORE_BITS-1:0]         l_a,
  input  wire logic [SCORE_BITS-1:0]         l_b,
  output logic      [SCORE_BITS-1:0]         new_m,
  output logic      [SCORE_BITS-1:0]         new_a,
  output logic      [SCORE_BITS-1:0]         new_b
);

  localparam int SW = SCORE_BITS + 2;
  localparam logic [SCORE_BITS-1:0] TOP = '1;

  function automatic logic [SCORE_BITS-1:0] clamp_score(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] top_s;
    top_s = signed'({2'b00, TOP});
    if (v < 0) return '0;
    if (v > top_s) return TOP;
    return v[SCORE_BITS-1:0];
  endfunction

  function automatic logic [SCORE_BITS-1:0] max_u(input logic [SCORE_BITS-1:0] a,
                                                  input logic [SCORE_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [SW-1:0] sext8(input logic [7:0] v);
    return signed'({{(SW-8){v[7]}}, v});
  endfunction

  logic                    eq;
  logic signed [SW-1:0]    sub_s;
  logic signed [SW-1:0]    ext_s;
  logic signed [SW-1:0]    opn_s;
  logic [SCORE_BITS-1:0]   d_max;
  logic signed [SW-1:0]    m_sum;
  logic signed [SW-1:0]    a_open;
  logic signed [SW-1:0]    a_ext;
  logic signed [SW-1:0]    b_open;
  logic signed [SW-1:0]    b_ext;

  always_comb begin
    eq     = (sym_a == sym_b);
    sub_s  = eq ? sext8(cfg.match_award) : sext8(cfg.mismatch_award);
    ext_s  = sext8(cfg.extend_cost);
    opn_s  = ext_s + sext8(cfg.open_cost);
    d_max  = max_u(max_u(d_m, d_a), d_b);
    m_sum  = signed'({2'b00, d_max}) + sub_s;
    a_open = signed'({2'b00, max_u(u_m, u_b)}) + opn_s;
    a_ext  = signed'({2'b00, u_a}) + ext_s;
    b_open = signed'({2'b00, max_u(l_m, l_a)}) + opn_s;
    b_ext  = signed'({2'b00, l_b}) + ext_s;

    new_m = (cfg.mm_dis && !eq) ? '0 : clamp_score(m_sum);
    new_a = cfg.gaps_dis ? '0 : clamp_score((a_open > a_ext) ? a_open : a_ext);
    new_b = cfg.gaps_dis ? '0 : clamp_score((b_open > b_ext) ? b_open : b_ext);
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the affine-gap local alignment row fill block
//
// loads sequence a symbols and streams sequence b symbols through the block
// under many gap and award settings, predicts every row's best match score
// and leftmost best column, and checks each result transaction in order
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SCORE_BITS     = lasf_pkg::DEF_SCORE_BITS;
  localparam int MAX_COLS       = lasf_pkg::DEF_MAX_A_LEN;
  localparam int ROW_BITS       = lasf_pkg::ROW_BITS;
  localparam int COL_BITS       = lasf_pkg::COL_BITS;
  localparam int SYM_BITS       = lasf_pkg::SYM_BITS;
  localparam int CFG_IDX_BITS   = lasf_pkg::CFG_IDX_BITS;
  localparam int CFG_DATA_BITS  = lasf_pkg::CFG_DATA_BITS;
  localparam int SCORE_TOP      = (1 << SCORE_BITS) - 1;
  localparam int NUM_PHASES     = 24;
  localparam int PHASE_ITEMS    = 23;
  localparam int FILL_COLS      = 64;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 1100;
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PRESSURE_PHASE = 10;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ROW  = 1'b1;

  typedef struct packed {
    logic [ROW_BITS-1:0]   row;
    logic [SCORE_BITS-1:0] score;
    logic [COL_BITS-1:0]   col;
  } row_result_t;

  class affine_row_scoreboard;
    logic [SYM_BITS-1:0]   a_sym  [MAX_COLS];
    logic [SCORE_BITS-1:0] m_row  [MAX_COLS];
    logic [SCORE_BITS-1:0] ga_row [MAX_COLS];
    logic [SCORE_BITS-1:0] gb_row [MAX_COLS];
    logic [ROW_BITS-1:0]   row_cnt;
    lasf_pkg::cfg_t        regs;
    logic [COL_BITS-1:0]   a_len;
    row_result_t           pending_rows [$];
    int                    mismatches;

    function new();
      row_cnt    = '0;
      regs       = lasf_pkg::CFG_RESET;
      a_len      = lasf_pkg::A_LENGTH_RESET;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        lasf_pkg::REG_MATCH_AWARD:    regs.match_award = data[7:0];
        lasf_pkg::REG_MISMATCH_AWARD: regs.mismatch_award = data[7:0];
        lasf_pkg::REG_GAP_OPEN:       regs.open_cost = data[7:0];
        lasf_pkg::REG_GAP_EXTEND:     regs.extend_cost = data[7:0];
        lasf_pkg::REG_GAPS_DIS:       regs.gaps_dis = data[0];
        lasf_pkg::REG_MISMATCHES_DIS: regs.mm_dis = data[0];
        lasf_pkg::REG_A_LENGTH:       a_len = data;
        default: ;
      endcase
    endfunction

    // max of the three candidates and zero, held at the top of the score range
    function int clamp_max(int a, int b, int c);
      int m;
      m = 0;
      if (a > m) m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      if (m > SCORE_TOP) m = SCORE_TOP;
      return m;
    endfunction

    function void fill_row(logic [SYM_BITS-1:0] b_sym, logic first);
      int n, ext, opn, ma, mm, s, best;
      int d_m, d_a, d_b, l_m, l_a, l_b, u_m, u_a, u_b, n_m, n_a, n_b;
      logic [COL_BITS-1:0] best_col;
      bit eq;
      row_result_t r;
      n = int'(a_len);
      if (n == 0) n = 1;
      if (n > MAX_COLS) n = MAX_COLS;
      ext = int'($signed(regs.extend_cost));
      opn = ext + int'($signed(regs.open_cost));
      ma = int'($signed(regs.match_award));
      mm = int'($signed(regs.mismatch_award));
      d_m = 0; d_a = 0; d_b = 0;
      l_m = 0; l_a = 0; l_b = 0;
      best = 0;
      best_col = COL_BITS'(1);
      for (int c = 0; c < n; c++) begin
        u_m = 0; u_a = 0; u_b = 0;
        if (!first) begin
          u_m = int'(m_row[c]);
          if (!regs.gaps_dis) begin
            u_a = int'(ga_row[c]);
            u_b = int'(gb_row[c]);
          end
        end
        eq = (a_sym[c] == b_sym);
        if (regs.mm_dis && !eq) begin
          n_m = 0;
        end else begin
          s = eq ? ma : mm;
          n_m = clamp_max(d_m + s, d_a + s, d_b + s);
        end
        n_a = 0;
        n_b = 0;
        if (!regs.gaps_dis) begin
          n_a = clamp_max(u_m + opn, u_a + ext, u_b + opn);
          n_b = clamp_max(l_m + opn, l_a + opn, l_b + ext);
        end
        m_row[c]  = n_m[SCORE_BITS-1:0];
        ga_row[c] = n_a[SCORE_BITS-1:0];
        gb_row[c] = n_b[SCORE_BITS-1:0];
        if (n_m > best) begin
          best = n_m;
          best_col = COL_BITS'(c + 1);
        end
        d_m = u_m; d_a = u_a; d_b = u_b;
        l_m = n_m; l_a = n_a; l_b = n_b;
      end
      if (first) begin
        row_cnt = ROW_BITS'(1);
      end else if (row_cnt < lasf_pkg::ROW_TOP) begin
        row_cnt = row_cnt + 1'b1;
      end
      r.row = row_cnt;
      r.score = best[SCORE_BITS-1:0];
      r.col = best_col;
      pending_rows.push_back(r);
    endfunction

    function void take_item(logic cmd, logic [SYM_BITS-1:0] sym, logic [9:0] pos, logic first);
      if (cmd == CMD_LOAD) begin
        if (pos < MAX_COLS) a_sym[pos] = sym;
      end else begin
        fill_row(sym, first);
      end
    endfunction

    function void check_row(logic [ROW_BITS-1:0] row, logic [SCORE_BITS-1:0] score,
                            logic [COL_BITS-1:0] col);
      row_result_t want;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row transaction, row %0d score %0d column %0d",
                 $time, row, score, col);
        mismatches++;
        return;
      end
      want = pending_rows.pop_front();
      if (row !== want.row) begin
        $display("%0t: row_number expected %0d actual %0d", $time, want.row, row);
        mismatches++;
      end
      if (score !== want.score) begin
        $display("%0t: best_score expected %0d actual %0d (row %0d)",
                 $time, want.score, score, want.row);
        mismatches++;
      end
      if (col !== want.col) begin
        $display("%0t: best_column expected %0d actual %0d (row %0d)",
                 $time, want.col, col, want.row);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_cmd = 1'b0;
  logic [SYM_BITS-1:0] in_symbol = '0;
  logic [9:0]          in_position = '0;
  logic                in_first_row = 1'b0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ROW_BITS-1:0]   out_row_number;
  logic [SCORE_BITS-1:0] out_best_score;
  logic [COL_BITS-1:0]   out_best_column;

  affine_row_scoreboard sb;
  int   snd_idle_pct = 33;
  int   rcv_idle_pct = 46;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  local_alignment_score_fill_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_symbol       (in_symbol),
    .in_position     (in_position),
    .in_first_row    (in_first_row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_number  (out_row_number),
    .out_best_score  (out_best_score),
    .out_best_column (out_best_column)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) sb.check_row(out_row_number, out_best_score, out_best_column);
      if (in_valid && in_ready) sb.take_item(in_cmd, in_symbol, in_position, in_first_row);
      if ((cfg_valid && cfg_ready) || (out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [SYM_BITS-1:0] pick_symbol();
    logic [SYM_BITS-1:0] alphabet [4];
    alphabet[0] = 8'h41;
    alphabet[1] = 8'h43;
    alphabet[2] = 8'h47;
    alphabet[3] = 8'h54;
    if ($urandom_range(9) == 0) return SYM_BITS'($urandom_range(255));
    return alphabet[$urandom_range(3)];
  endfunction

  task automatic set_idle_mode(input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct <= rcv_pct;
  endtask

  task automatic send_item(input logic cmd, input logic [SYM_BITS-1:0] sym,
                           input logic [9:0] pos, input logic first);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_symbol    <= sym;
    in_position  <= pos;
    in_first_row <= first;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait until every row has come back, then idle for the given gap
  task automatic settle(input int gap);
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (gap) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input lasf_pkg::cfg_t c, input logic [COL_BITS-1:0] len);
    settle(SETTLE_CYCLES);
    cfg_write(lasf_pkg::REG_MATCH_AWARD, {3'b000, c.match_award});
    cfg_write(lasf_pkg::REG_MISMATCH_AWARD, {3'b000, c.mismatch_award});
    cfg_write(lasf_pkg::REG_GAP_OPEN, {3'b000, c.open_cost});
    cfg_write(lasf_pkg::REG_GAP_EXTEND, {3'b000, c.extend_cost});
    cfg_write(lasf_pkg::REG_GAPS_DIS, {10'd0, c.gaps_dis});
    cfg_write(lasf_pkg::REG_MISMATCHES_DIS, {10'd0, c.mm_dis});
    cfg_write(lasf_pkg::REG_A_LENGTH, len);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    cfg_write(lasf_pkg::REG_A_LENGTH, 11'd4);
    cfg_valid <= 1'b0;
    send_item(CMD_LOAD, 8'h00, 10'd0, 1'b0);
    send_item(CMD_LOAD, 8'hFF, 10'd1, 1'b1);
    send_item(CMD_LOAD, 8'h00, 10'd2, 1'b0);
    send_item(CMD_LOAD, 8'hFF, 10'd3, 1'b0);
    send_item(CMD_LOAD, 8'hFF, 10'd1023, 1'b1);
    send_item(CMD_ROW, 8'h00, 10'd0, 1'b1);
    send_item(CMD_ROW, 8'hFF, 10'd1023, 1'b0);
    send_item(CMD_ROW, 8'h00, 10'd0, 1'b0);
    send_item(CMD_ROW, 8'hFF, 10'd0, 1'b0);
    // no symbol matches on a fresh row: best score zero in column one
    send_item(CMD_ROW, 8'h5A, 10'd0, 1'b1);
    send_item(CMD_ROW, 8'hFF, 10'd0, 1'b0);
    send_item(CMD_LOAD, 8'hFF, 10'd2, 1'b0);
    send_item(CMD_ROW, 8'hFF, 10'd0, 1'b0);
    send_item(CMD_ROW, 8'hFF, 10'd0, 1'b1);
  endtask

  task automatic run_phase(input int p);
    lasf_pkg::cfg_t c;
    logic [COL_BITS-1:0] len;
    int items, load_pct, restart_pct, n;
    logic first;
    if (p < 8) begin
      set_idle_mode(33, 46);
    end else if (p < 16) begin
      set_idle_mode(46, 33);
    end else begin
      set_idle_mode(0, 0);
    end
    c = lasf_pkg::CFG_RESET;
    len = 11'd16;
    items = PHASE_ITEMS;
    load_pct = 20;
    restart_pct = 8;
    case (p)
      0: begin
        len = 11'(FILL_COLS);
        items = 3;
        load_pct = 0;
      end
      1: begin
        c.match_award = 8'h7F; c.mismatch_award = 8'h80;
        c.open_cost = 8'h00; c.extend_cost = 8'h00;
        len = 11'd8;
      end
      2: begin
        c.match_award = 8'h80; c.mismatch_award = 8'h7F;
        c.open_cost = 8'h80; c.extend_cost = 8'h80;
        len = 11'd1;
      end
      3: begin
        c.match_award = 8'd5; c.mismatch_award = 8'hFD;
        c.open_cost = 8'hFC; c.gaps_dis = 1'b1;
        len = 11'd12;
      end
      4: begin
        c.match_award = 8'd3; c.mismatch_award = 8'hFE;
        c.open_cost = 8'hFD; c.mm_dis = 1'b1;
        len = 11'd0;
      end
      5: begin
        c.match_award = 8'd2;
        len = 11'(FILL_COLS);
        items = 3;
        load_pct = 0;
      end
      PRESSURE_PHASE: begin
        c.match_award = 8'd4;
        len = 11'd4;
        items = 40;
      end
      default: begin
        c.match_award = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(1, 12));
        c.mismatch_award = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                    : 8'(-$urandom_range(0, 6));
        c.open_cost = ($urandom_range(7) == 0) ? 8'(-$urandom_range(0, 128))
                                               : 8'(-$urandom_range(0, 8));
        c.extend_cost = 8'(-$urandom_range(0, 3));
        c.gaps_dis = ($urandom_range(4) == 0);
        c.mm_dis = ($urandom_range(4) == 0);
        len = ($urandom_range(9) == 0) ? 11'($urandom_range(1, FILL_COLS))
                                       : 11'($urandom_range(1, 20));
      end
    endcase
    apply_settings(c, len);
    if (p == PRESSURE_PHASE) hold_req <= 1'b1;
    if (p == 0) begin
      for (int i = 0; i < FILL_COLS; i++) send_item(CMD_LOAD, pick_symbol(), 10'(i), 1'b0);
    end
    n = (len == 0) ? 1 : (len > MAX_COLS) ? MAX_COLS : len;
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(99) < load_pct) begin
        send_item(CMD_LOAD, pick_symbol(),
                  ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                           : 10'($urandom_range(n - 1)),
                  1'($urandom_range(1)));
      end else begin
        first = (k == 0) || ($urandom_range(99) < restart_pct);
        send_item(CMD_ROW, pick_symbol(), 10'($urandom_range(1023)), first);
      end
    end
  endtask

  initial begin
    sb = new();
    set_idle_mode(33, 46);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) run_phase(p);
    settle(DRAIN_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
